FILE: sv/pwm_period_duty_monitor_defines.svh
// Assertion macros shared by the PWM monitor modules.
`ifndef PWM_PERIOD_DUTY_MONITOR_DEFINES_SVH
`define PWM_PERIOD_DUTY_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PWM_MON_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PWM_MON_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pwm_mon_pkg.sv
// Shared types and constants of the PWM period and duty monitor.
package pwm_mon_pkg;

    localparam int EDGE_COUNT_DEF = 10;

    localparam int CNT_W   = 4;   // edge counter width
    localparam int TIME_W  = 32;  // window tick count and edge stamps
    localparam int FREQ_W  = 27;
    localparam int DUTY_W  = 8;
    localparam int RATE_W  = 27;

    // Shared divider: 40-bit dividend (255 * 32-bit half period), 32-bit divisor
    localparam int DIV_W   = 40;
    localparam int DVS_W   = 32;
    localparam int DCNT_W  = $clog2(DIV_W + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_DUTY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE_HZ  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd4;

    localparam logic [RATE_W-1:0] TICK_RATE_RST = 27'd1000000;
    localparam logic [TIME_W-1:0] TIMEOUT_RST   = 32'd3000000;

    // Result kinds
    localparam logic KIND_MEAS = 1'b0;
    localparam logic KIND_TMO  = 1'b1;

    // Tracker to sequencer: what the accepted tick caused
    typedef struct packed {
        logic measure;  // last edge of the run seen, stamps complete
        logic timeout;  // window ran past timeout_ticks
    } trk_evt_t;

    // Stamps of the last three pin transitions of the run, oldest first
    typedef struct packed {
        logic [TIME_W-1:0] t1;
        logic [TIME_W-1:0] t2;
        logic [TIME_W-1:0] t3;
    } trk_times_t;

endpackage

FILE: sv/pwm_mon_div.sv
// Restoring divider, one quotient bit per clock, shared by all three divisions.
`include "pwm_period_duty_monitor_defines.svh"

module pwm_mon_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pwm_mon_pkg::DIV_W-1:0] dividend,
    input  logic [pwm_mon_pkg::DVS_W-1:0] divisor,
    output logic                          busy,
    output logic                          done,
    output logic [pwm_mon_pkg::DIV_W-1:0] quotient
);
    import pwm_mon_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;

    logic [DVS_W:0]    rem_sh;
    logic [DVS_W+1:0]  diff;
    logic              take;
    logic              in_use;

    always_comb begin
        rem_sh = {rem_reg, quo_reg[DIV_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
        take   = !diff[DVS_W+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = take ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], take};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
    assign in_use   = busy_reg || done_reg;

    `PWM_MON_ASSERT(a_div_no_restart, aclk, aresetn, start, !in_use, "divider restarted while in use")
    `PWM_MON_ASSERT_NEXT(a_div_start_busy, aclk, aresetn, start, busy_reg, "divider not busy after start")

endmodule

FILE: sv/pwm_mon_trk.sv
// Window tick counter and edge stamping of the monitored pin.
module pwm_mon_trk #(
    parameter int EDGE_COUNT = pwm_mon_pkg::EDGE_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           enable,
    input  logic                           tick,
    input  logic                           level,
    input  logic [pwm_mon_pkg::TIME_W-1:0] timeout_ticks,
    output pwm_mon_pkg::trk_evt_t          evt,
    output pwm_mon_pkg::trk_times_t        times
);
    import pwm_mon_pkg::*;

    localparam logic [CNT_W-1:0] EDGES     = CNT_W'(EDGE_COUNT);
    localparam logic [CNT_W-1:0] SLOT_BASE = CNT_W'(EDGE_COUNT - 3);

    logic [TIME_W-1:0] window_reg, window_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              prev_reg, prev_next;
    logic              primed_reg, primed_next;
    logic [TIME_W-1:0] stamp_reg [3];

    logic [TIME_W-1:0] win_inc;
    logic              is_edge;
    logic [CNT_W-1:0]  count_after;
    logic [CNT_W-1:0]  slot;
    logic              measure;
    logic              timeout;

    always_comb begin
        win_inc     = (window_reg == '1) ? window_reg : window_reg + 1'b1;
        is_edge     = primed_reg && (level != prev_reg) && (count_reg < EDGES);
        count_after = is_edge ? count_reg + 1'b1 : count_reg;
        slot        = count_reg - SLOT_BASE;
        measure     = enable && (count_after >= EDGES);
        timeout     = enable && !measure && (win_inc > timeout_ticks);

        window_next = window_reg;
        count_next  = count_reg;
        prev_next   = prev_reg;
        primed_next = primed_reg;
        if (!enable) begin
            window_next = '0;
            count_next  = '0;
            prev_next   = 1'b0;
            primed_next = 1'b0;
        end else if (tick) begin
            window_next = (measure || timeout) ? '0 : win_inc;
            count_next  = (measure || timeout) ? '0 : count_after;
            prev_next   = level;
            primed_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            count_reg  <= '0;
            prev_reg   <= 1'b0;
            primed_reg <= 1'b0;
        end else begin
            window_reg <= window_next;
            count_reg  <= count_next;
            prev_reg   <= prev_next;
            primed_reg <= primed_next;
        end
    end

    // Only the stamps of the last three pin transitions of a run are kept
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (enable && tick && is_edge && (count_reg >= SLOT_BASE)
                && (slot[1:0] == 2'(i))) begin
                stamp_reg[i] <= win_inc;
            end
        end
    end

    assign evt.measure = measure;
    assign evt.timeout = timeout;
    assign times.t1    = stamp_reg[0];
    assign times.t2    = stamp_reg[1];
    assign times.t3    = stamp_reg[2];

endmodule

FILE: sv/pwm_period_duty_monitor.sv
// Top level of the PWM period and duty monitor: config, sequencer, output register.
//
// Each input request is one timebase tick carrying the sampled pin level. While
// enable is set the block counts ticks in a window and counts pin edges, keeping
// stamps of the last three; when the EDGE_COUNT-th edge arrives it takes the
// period T from those three stamps and reports tick_rate_hz / T plus a duty
// estimate 255*d/T+1 from the half period closer to expected_duty (ties go to
// the later half), with a flag set when frequency or duty differ from the
// previous measurement. A window longer than timeout_ticks reports a timeout
// with the pin level (inverted if invert_level is set). Every result restarts
// the window. A tick that ends in no result or in a timeout leaves the block
// idle; a tick that completes a measurement holds s_tready low while the single
// restoring divider (one quotient bit per clock) runs frequency, later-half and
// earlier-half divisions in turn. s_tready also waits while a result sits
// unaccepted in the output register. Configuration must be written only while
// the block is idle; the block itself does not enforce this.
`include "pwm_period_duty_monitor_defines.svh"

module pwm_period_duty_monitor #(
    parameter int EDGE_COUNT = pwm_mon_pkg::EDGE_COUNT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Tick requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [0] pin_level
    // Results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,   // [26:0] freq_hz, [34:27] duty_255,
                                                          // [35] level_high, [36] changed
    output logic                               m_tuser,   // [0] result_kind
    // Configuration writes
    input  logic                               cfg_we,
    input  logic [pwm_mon_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwm_mon_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pwm_mon_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_FREQ  = 6'b000100,
        S_LATE  = 6'b001000,
        S_EARLY = 6'b010000,
        S_PICK  = 6'b100000
    } state_t;

    // Configuration registers
    logic              enable_reg;
    logic [DUTY_W-1:0] exp_duty_reg;
    logic              invert_reg;
    logic [RATE_W-1:0] tick_rate_reg;
    logic [TIME_W-1:0] timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            exp_duty_reg  <= '0;
            invert_reg    <= 1'b0;
            tick_rate_reg <= TICK_RATE_RST;
            timeout_reg   <= TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ENABLE:        enable_reg    <= cfg_data[0];
                CFG_EXPECTED_DUTY: exp_duty_reg  <= cfg_data[DUTY_W-1:0];
                CFG_INVERT_LEVEL:  invert_reg    <= cfg_data[0];
                CFG_TICK_RATE_HZ:  tick_rate_reg <= cfg_data[RATE_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_reg   <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake
    logic       out_free;
    logic       s_accept;
    state_t     state_reg, state_next;
    logic       m_valid_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    // Edge tracker
    trk_evt_t   evt;
    trk_times_t times;

    pwm_mon_trk #(
        .EDGE_COUNT(EDGE_COUNT)
    ) u_trk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .enable        (enable_reg),
        .tick          (s_accept),
        .level         (s_tdata[0]),
        .timeout_ticks (timeout_reg),
        .evt           (evt),
        .times         (times)
    );

    // Shared divider
    logic              go_reg, go_next;
    logic [DIV_W-1:0]  div_dividend;
    logic              div_busy;
    logic              div_done;
    logic [DIV_W-1:0]  div_q;

    logic [TIME_W-1:0] period_reg, late_num_reg, early_num_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [DUTY_W-1:0] d_late_reg, d_early_reg;
    logic [FREQ_W-1:0] last_freq_reg;
    logic [DUTY_W-1:0] last_duty_reg;

    // 255 * x as (x << 8) - x
    function automatic logic [DIV_W-1:0] mul255(input logic [TIME_W-1:0] x);
        return {x, 8'h00} - {8'h00, x};
    endfunction

    // q + 1, clamped to 255
    function automatic logic [DUTY_W-1:0] duty_sat(input logic [DIV_W-1:0] q);
        logic big;
        big = (q[DIV_W-1:DUTY_W] != '0) || (q[DUTY_W-1:0] == '1);
        return big ? '1 : q[DUTY_W-1:0] + 1'b1;
    endfunction

    always_comb begin
        case (state_reg)
            S_LATE:  div_dividend = mul255(late_num_reg);
            S_EARLY: div_dividend = mul255(early_num_reg);
            default: div_dividend = {{(DIV_W - RATE_W){1'b0}}, tick_rate_reg};
        endcase
    end

    pwm_mon_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (go_reg),
        .dividend (div_dividend),
        .divisor  (period_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Estimate choice; ties keep the later half
    logic [DUTY_W-1:0] err_late, err_early, duty_pick;
    logic              changed;

    always_comb begin
        err_late  = (exp_duty_reg > d_late_reg)  ? exp_duty_reg - d_late_reg
                                                 : d_late_reg - exp_duty_reg;
        err_early = (exp_duty_reg > d_early_reg) ? exp_duty_reg - d_early_reg
                                                 : d_early_reg - exp_duty_reg;
        duty_pick = (err_late > err_early) ? d_early_reg : d_late_reg;
        changed   = (freq_reg != last_freq_reg) || (duty_pick != last_duty_reg);
    end

    // Sequencer
    logic load_meas, load_tmo;

    always_comb begin
        state_next = state_reg;
        go_next    = 1'b0;
        load_meas  = 1'b0;
        load_tmo   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_accept && evt.measure) begin
                    state_next = S_SETUP;
                end else if (s_accept && evt.timeout) begin
                    load_tmo = 1'b1;
                end
            end
            S_SETUP: begin
                state_next = S_FREQ;
                go_next    = 1'b1;
            end
            S_FREQ: begin
                if (div_done) begin
                    state_next = S_LATE;
                    go_next    = 1'b1;
                end
            end
            S_LATE: begin
                if (div_done) begin
                    state_next = S_EARLY;
                    go_next    = 1'b1;
                end
            end
            S_EARLY: begin
                if (div_done) begin
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                if (out_free) begin
                    load_meas  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            last_freq_reg <= '0;
            last_duty_reg <= '0;
        end else begin
            state_reg <= state_next;
            go_reg    <= go_next;
            if (load_meas) begin
                last_freq_reg <= freq_reg;
                last_duty_reg <= duty_pick;
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge aclk) begin
        if (state_reg == S_SETUP) begin
            // stamps are distinct in practice; a zero period is forced to one
            period_reg    <= (times.t3 == times.t1) ? TIME_W'(1) : times.t3 - times.t1;
            late_num_reg  <= times.t3 - times.t2;
            early_num_reg <= times.t2 - times.t1;
        end
        if (div_done && (state_reg == S_FREQ)) begin
            freq_reg <= div_q[FREQ_W-1:0];
        end
        if (div_done && (state_reg == S_LATE)) begin
            d_late_reg <= duty_sat(div_q);
        end
        if (div_done && (state_reg == S_EARLY)) begin
            d_early_reg <= duty_sat(div_q);
        end
    end

    // Output register
    logic              out_kind_reg;
    logic [FREQ_W-1:0] out_freq_reg;
    logic [DUTY_W-1:0] out_duty_reg;
    logic              out_level_reg;
    logic              out_changed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_meas || load_tmo) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_tmo) begin
            out_kind_reg    <= KIND_TMO;
            out_freq_reg    <= '0;
            out_duty_reg    <= '0;
            out_level_reg   <= s_tdata[0] ^ invert_reg;
            out_changed_reg <= 1'b0;
        end else if (load_meas) begin
            out_kind_reg    <= KIND_MEAS;
            out_freq_reg    <= freq_reg;
            out_duty_reg    <= duty_pick;
            out_level_reg   <= 1'b0;
            out_changed_reg <= changed;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {3'b000, out_changed_reg, out_level_reg, out_duty_reg, out_freq_reg};

    // Assertion helpers
    logic in_div_state, out_meas, out_tmo, tmo_clear;

    assign in_div_state = (state_reg == S_FREQ) || (state_reg == S_LATE)
                          || (state_reg == S_EARLY);
    assign out_meas     = m_valid_reg && (out_kind_reg == KIND_MEAS);
    assign out_tmo      = m_valid_reg && (out_kind_reg == KIND_TMO);
    assign tmo_clear    = (out_freq_reg == '0) && (out_duty_reg == '0) && !out_changed_reg;

    `PWM_MON_ASSERT(a_done_in_div_state, aclk, aresetn, div_done, in_div_state, "stray divider result")
    `PWM_MON_ASSERT(a_meas_duty_nonzero, aclk, aresetn, out_meas, out_duty_reg != '0, "zero duty")
    `PWM_MON_ASSERT(a_tmo_fields_clear, aclk, aresetn, out_tmo, tmo_clear, "timeout fields set")
    `PWM_MON_ASSERT(a_div_free_in_idle, aclk, aresetn, state_reg == S_IDLE, !div_busy, "busy in idle")

endmodule

FILE: tb/sv/pwm_period_duty_monitor_tb.sv
// Self-checking testbench of the PWM period and duty monitor.
`timescale 1ns / 100ps

module pwm_period_duty_monitor_tb;
    import pwm_mon_pkg::*;

    localparam int EDGE_N    = EDGE_COUNT_DEF;
    localparam int SETTLE_CY = 200;     // outlasts the divisions of a measurement
    localparam int HOLD_CY   = 600;     // long receiver hold-off

    // One result as the block reports it
    typedef struct packed {
        logic              kind;
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
        logic              level_high;
        logic              changed;
    } pwm_result_t;

    // Directed stimulus rows: a register write, a tick checked by the
    // predictor, or a tick whose outcome is typed in
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_TICK,
        ROW_TICK_TYPED
    } row_op_t;

    typedef struct packed {
        row_op_t                 op;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic                    lvl;
        bit                      typed_has;
        pwm_result_t             typed_res;
    } dir_row_t;

    // DUT ports; every input known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;      // [0] pin_level
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;             // [26:0] freq, [34:27] duty, [35] level, [36] changed
    logic                  m_tuser;             // [0] result_kind
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers
    logic                  pm_enable   = 1'b0;
    logic [DUTY_W-1:0]     pm_exp_duty = '0;
    logic                  pm_invert   = 1'b0;
    logic [RATE_W-1:0]     pm_rate     = TICK_RATE_RST;
    logic [TIME_W-1:0]     pm_timeout  = TIMEOUT_RST;

    // Predictor copy of the window state
    logic [TIME_W-1:0]     win_cnt    = '0;
    logic [CNT_W-1:0]      edges_seen = '0;
    logic                  last_lvl   = 1'b0;
    logic                  lvl_valid  = 1'b0;
    logic [TIME_W-1:0]     stamp [3];
    logic [FREQ_W-1:0]     prev_freq  = '0;
    logic [DUTY_W-1:0]     prev_duty  = '0;

    pwm_result_t pending_results [$];   // results still owed by the block
    dir_row_t    dir_rows [$];

    int err_cnt   = 0;
    int gap_pct   = 0;                  // chance of a sender idle cycle
    int stall_pct = 0;                  // chance of a receiver stall cycle
    bit hold_req  = 1'b0;               // asks the receiver for a long hold-off
    int hold_left = 0;

    pwm_period_duty_monitor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Hard stop in case the block hangs
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic pwm_result_t mk_result(input logic kind, input logic [FREQ_W-1:0] freq,
                                              input logic [DUTY_W-1:0] duty,
                                              input logic lvl, input logic chg);
        pwm_result_t r;
        r.kind       = kind;
        r.freq       = freq;
        r.duty       = duty;
        r.level_high = lvl;
        r.changed    = chg;
        return r;
    endfunction

    // Clearing enable drops the window, the edge run and the level tracking
    task automatic clear_window();
        win_cnt    = '0;
        edges_seen = '0;
        last_lvl   = 1'b0;
        lvl_valid  = 1'b0;
    endtask

    // Expected outcome of one accepted tick; updates the predictor state
    task automatic predict_tick(input logic lvl, output bit has_res, output pwm_result_t res);
        logic [TIME_W-1:0] period, half_late, half_early;
        logic [31:0]       d_late, d_early, err_late, err_early;
        logic [63:0]       q;
        has_res = 1'b0;
        res     = '0;
        if (!pm_enable) return;

        // count first, then stamp the edge with the new count
        if (win_cnt != '1) win_cnt++;
        if (lvl_valid && lvl != last_lvl && edges_seen < EDGE_N) begin
            if (edges_seen >= EDGE_N - 3) stamp[edges_seen - (EDGE_N - 3)] = win_cnt;
            edges_seen++;
        end
        last_lvl  = lvl;
        lvl_valid = 1'b1;

        // a completed measurement wins over a timeout on the same tick
        if (edges_seen >= EDGE_N) begin
            period     = stamp[2] - stamp[0];
            half_late  = stamp[2] - stamp[1];
            half_early = stamp[1] - stamp[0];
            if (period == 0) period = 1;
            q       = 64'd255 * half_late / period;
            d_late  = q[31:0] + 1;
            q       = 64'd255 * half_early / period;
            d_early = q[31:0] + 1;
            if (d_late > 255) d_late = 255;
            if (d_early > 255) d_early = 255;
            err_late  = (pm_exp_duty > d_late) ? pm_exp_duty - d_late : d_late - pm_exp_duty;
            err_early = (pm_exp_duty > d_early) ? pm_exp_duty - d_early : d_early - pm_exp_duty;
            res.kind = KIND_MEAS;
            q        = pm_rate / period;
            res.freq = q[FREQ_W-1:0];
            res.duty = (err_late > err_early) ? d_early[DUTY_W-1:0] : d_late[DUTY_W-1:0];
            res.changed = (res.freq != prev_freq) || (res.duty != prev_duty);
            prev_freq  = res.freq;
            prev_duty  = res.duty;
            win_cnt    = '0;
            edges_seen = '0;
            has_res    = 1'b1;
            return;
        end

        // timeout keeps the last measurement untouched
        if (win_cnt > pm_timeout) begin
            res.kind       = KIND_TMO;
            res.level_high = lvl ^ pm_invert;
            win_cnt        = '0;
            edges_seen     = '0;
            has_res        = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_cnt++;
        if (err_cnt <= 40)
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // Register write, only issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ENABLE: begin
                pm_enable = val[0];
                if (!val[0]) clear_window();
            end
            CFG_EXPECTED_DUTY: pm_exp_duty = val[DUTY_W-1:0];
            CFG_INVERT_LEVEL:  pm_invert   = val[0];
            CFG_TICK_RATE_HZ:  pm_rate     = val[RATE_W-1:0];
            CFG_TIMEOUT_TICKS: pm_timeout  = val;
            default: ;
        endcase
    endtask

    // One tick request; the expectation is queued once the block takes it.
    // Typed rows override what the predictor says (the predictor still steps).
    task automatic send_tick(input logic lvl, input bit typed, input bit typed_has,
                             input pwm_result_t typed_res);
        bit          has;
        pwm_result_t res;
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, lvl};
        do @(posedge aclk); while (!s_tready);
        predict_tick(lvl, has, res);
        if (typed) begin
            has = typed_has;
            res = typed_res;
        end
        if (has) pending_results.push_back(res);
    endtask

    // Random tick, skipped once the phase has all its items
    task automatic send_capped(input logic lvl, input int n_items, inout int sent);
        if (sent < n_items) begin
            send_tick(lvl, 1'b0, 1'b0, '0);
            sent++;
        end
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Quiet the input, collect every owed result, then let a measurement
    // that produces nothing settle before touching the registers
    task automatic drain();
        stop_sending();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CY) @(posedge aclk);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r      = '0;
        r.op   = ROW_CFG;
        r.idx  = idx;
        r.data = val;
        dir_rows.push_back(r);
    endtask

    task automatic add_tick(input logic lvl);
        dir_row_t r;
        r     = '0;
        r.op  = ROW_TICK;
        r.lvl = lvl;
        dir_rows.push_back(r);
    endtask

    task automatic add_typed(input logic lvl, input bit has, input pwm_result_t res);
        dir_row_t r;
        r           = '0;
        r.op        = ROW_TICK_TYPED;
        r.lvl       = lvl;
        r.typed_has = has;
        r.typed_res = res;
        dir_rows.push_back(r);
    endtask

    // Random tick stream: mostly steady PWM bursts, some noise and flat
    // stretches that run into the timeout. Optional mid-phase pressure:
    // a long receiver hold-off, or a sender pause until all results are in.
    task automatic run_phase(input int n_items, input bit do_hold, input bit do_pause);
        int   sent, hi_len, lo_len, reps, r, k;
        bit   pressed;
        logic lvl;
        sent    = 0;
        pressed = 1'b0;
        while (sent < n_items) begin
            if (!pressed && sent >= n_items / 3) begin
                pressed = 1'b1;
                if (do_hold) hold_req = 1'b1;
                if (do_pause) begin
                    stop_sending();
                    while (pending_results.size() != 0) @(posedge aclk);
                end
            end
            r = $urandom_range(99);
            if (r < 70) begin
                hi_len = (r < 8) ? $urandom_range(1, 40) : $urandom_range(1, 8);
                lo_len = (r < 8) ? $urandom_range(1, 40) : $urandom_range(1, 8);
                reps   = $urandom_range(3, 12);
                repeat (reps) begin
                    repeat (hi_len) send_capped(1'b1, n_items, sent);
                    repeat (lo_len) send_capped(1'b0, n_items, sent);
                end
            end else if (r < 85) begin
                k = $urandom_range(1, 20);
                repeat (k) send_capped(1'($urandom_range(1)), n_items, sent);
            end else begin
                lvl = 1'($urandom_range(1));
                k   = $urandom_range(10, 150);
                repeat (k) send_capped(lvl, n_items, sent);
            end
        end
    endtask

    // Receiver: random stalls, or a counted hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CY;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker: each accepted result against the oldest expectation
    always @(posedge aclk) begin : chk_result
        pwm_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, tdata", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("result_kind", m_tuser, want.kind);
                if (m_tdata[26:0] !== want.freq)
                    report_mismatch("freq_hz", m_tdata[26:0], want.freq);
                if (m_tdata[34:27] !== want.duty)
                    report_mismatch("duty_255", m_tdata[34:27], want.duty);
                if (m_tdata[35] !== want.level_high)
                    report_mismatch("level_high", m_tdata[35], want.level_high);
                if (m_tdata[36] !== want.changed)
                    report_mismatch("changed", m_tdata[36], want.changed);
            end
        end
    end

    // Main sequence
    initial begin
        int                    duty_v, rate_v, n_items;
        logic                  inv_v;
        logic [CFG_DATA_W-1:0] tmo_v;
        bit                    need_drain;

        // --- directed rows ---
        // disabled after reset: tick is ignored
        add_typed(1'b1, 1'b0, '0);
        // zero timeout: every enabled tick times out, level reported inverted
        add_cfg(CFG_TIMEOUT_TICKS, 32'd0);
        add_cfg(CFG_INVERT_LEVEL, 32'd1);
        add_cfg(CFG_ENABLE, 32'd1);
        add_typed(1'b1, 1'b1, mk_result(KIND_TMO, '0, '0, 1'b0, 1'b0));
        add_typed(1'b0, 1'b1, mk_result(KIND_TMO, '0, '0, 1'b1, 1'b0));
        // no timeout, zero tick rate: toggling every tick gives T = 2,
        // equal halves, duty 128, freq 0; first measurement always changed
        add_cfg(CFG_INVERT_LEVEL, 32'd0);
        add_cfg(CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
        add_cfg(CFG_TICK_RATE_HZ, 32'd0);
        add_cfg(CFG_EXPECTED_DUTY, 32'd0);
        for (int i = 0; i < EDGE_N - 1; i++) add_tick(i % 2 == 0);
        add_typed(1'b0, 1'b1, mk_result(KIND_MEAS, '0, 8'd128, 1'b0, 1'b1));
        // full-scale tick rate, same waveform: only freq moves
        add_cfg(CFG_TICK_RATE_HZ, 32'h07FF_FFFF);
        add_cfg(CFG_EXPECTED_DUTY, 32'd255);
        for (int i = 0; i < EDGE_N - 1; i++) add_tick(i % 2 == 0);
        add_typed(1'b0, 1'b1, mk_result(KIND_MEAS, 27'd67108863, 8'd128, 1'b0, 1'b1));
        // disabling drops everything
        add_cfg(CFG_ENABLE, 32'd0);
        add_typed(1'b1, 1'b0, '0);

        // reset: held low, released on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        need_drain = 1'b0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                if (need_drain) begin
                    drain();
                    need_drain = 1'b0;
                end
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_tick(dir_rows[i].lvl, dir_rows[i].op == ROW_TICK_TYPED,
                          dir_rows[i].typed_has, dir_rows[i].typed_res);
                need_drain = 1'b1;
            end
        end

        // --- random phases: settings and idling change per phase ---
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            duty_v  = $urandom_range(255);
            inv_v   = 1'($urandom_range(1));
            rate_v  = $urandom_range(0, 27'h7FF_FFFF);
            tmo_v   = $urandom_range(20, 500);
            n_items = 230;
            case (ph)
                0: begin
                    duty_v = 0; inv_v = 1'b0; rate_v = 1; tmo_v = 32'hFFFF_FFFF;
                    gap_pct = 0;  stall_pct = 0;
                end
                1: begin
                    duty_v = 255; inv_v = 1'b1; rate_v = 100_000_000;
                    tmo_v = $urandom_range(40, 300);
                    gap_pct = 75; stall_pct = 0;
                end
                2: begin
                    // timeout of one tick: results on nearly every other tick
                    inv_v = 1'b0; rate_v = 1_000_000; tmo_v = 32'd1; n_items = 150;
                    gap_pct = 0;  stall_pct = 75;
                end
                3: begin
                    inv_v = 1'b1; rate_v = $urandom_range(1, 27'h7FF_FFFF);
                    tmo_v = $urandom_range(40, 300);
                    gap_pct = 19; stall_pct = 19;
                end
                4: begin
                    duty_v = 128; rate_v = 27'h7FF_FFFF; tmo_v = $urandom_range(100, 2000);
                    gap_pct = 0;  stall_pct = 0;
                end
                5: begin
                    gap_pct = 75; stall_pct = 0;
                end
                6: begin
                    gap_pct = 0;  stall_pct = 75;
                end
                default: begin
                    // full-width timeout, rarely reached
                    tmo_v   = $urandom();
                    gap_pct = 19; stall_pct = 19;
                end
            endcase
            write_reg(CFG_ENABLE, 32'd0);
            write_reg(CFG_EXPECTED_DUTY, duty_v);
            write_reg(CFG_INVERT_LEVEL, {31'd0, inv_v});
            write_reg(CFG_TICK_RATE_HZ, rate_v);
            write_reg(CFG_TIMEOUT_TICKS, tmo_v);
            write_reg(CFG_ENABLE, 32'd1);
            run_phase(n_items, ph == 3, ph == 4);
        end

        // wait out every owed result plus settle time; stray results get caught
        drain();
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
